// File: design/slrp_pkg.sv
// Shared types and constants for the sensor log record parser.
package slrp_pkg;

    localparam int BUF_DEPTH = 22;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int Q_DEPTH   = 2;

    // Accepted values of the top nibble of the first header byte.
    localparam logic [3:0] HDR_TOP_SENSOR = 4'hC;
    localparam logic [3:0] HDR_TOP_FULL   = 4'hF;

    // Flag positions within the header's top nibble.
    localparam int FLAG_ACC  = 3;
    localparam int FLAG_GYRO = 2;
    localparam int FLAG_PRES = 1;
    localparam int FLAG_TEMP = 0;

    localparam logic [CNT_W-1:0] LEN_ACC  = CNT_W'(6);
    localparam logic [CNT_W-1:0] LEN_GYRO = CNT_W'(6);
    localparam logic [CNT_W-1:0] LEN_PRES = CNT_W'(7);
    localparam logic [CNT_W-1:0] LEN_TEMP = CNT_W'(3);

    // Fixed byte offsets of the decoded fields in the payload buffer.
    localparam int OFS_ACC  = 0;
    localparam int OFS_GYRO = 6;
    localparam int OFS_PRES = 12;
    localparam int OFS_TEMP = 15;
    localparam int OFS_ALT  = 18;

    typedef logic [BUF_DEPTH-1:0][7:0] t_payload;

    // One finished record, or a bad header, handed from front to back.
    typedef struct packed {
        logic       bad;
        logic [3:0] flags;
        logic [7:0] evt;
        logic [11:0] dt;
        t_payload   bytes;
    } t_rec;

endpackage

// File: design/sensor_log_record_parser_core.sv
// Top level of the sensor log record parser: front end, record queue, back end.
// Throughput: one log byte per clock; ready drops only while the record queue is full.
// A finished record passes through the record queue and then the result register.
// The queue of QUEUE_DEPTH records lets the back end stall without stopping intake.
// Reset is synchronous and active low; all state but the queue storage clears, no clearing pass.
module sensor_log_record_parser_core #(
    parameter int QUEUE_DEPTH = slrp_pkg::Q_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_log_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_status,
    output logic [31:0]        o_abs_time,
    output logic signed [15:0] o_accel_x,
    output logic signed [15:0] o_accel_y,
    output logic signed [15:0] o_accel_z,
    output logic signed [15:0] o_gyro_x,
    output logic signed [15:0] o_gyro_y,
    output logic signed [15:0] o_gyro_z,
    output logic [23:0]        o_pressure,
    output logic [23:0]        o_temperature,
    output logic [31:0]        o_altitude_bits,
    output logic [7:0]         o_event_sum
);
    import slrp_pkg::*;

    logic w_push, w_full, w_nonempty, w_pop;
    t_rec w_push_rec, w_head_rec;

    assign o_ready = !w_full;

    slrp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (i_valid && o_ready),
        .i_log_byte (i_log_byte),
        .o_push     (w_push),
        .o_rec      (w_push_rec)
    );

    slrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_rec      (w_push_rec),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_rec      (w_head_rec)
    );

    slrp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec_valid     (w_nonempty),
        .i_rec           (w_head_rec),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_abs_time      (o_abs_time),
        .o_accel_x       (o_accel_x),
        .o_accel_y       (o_accel_y),
        .o_accel_z       (o_accel_z),
        .o_gyro_x        (o_gyro_x),
        .o_gyro_y        (o_gyro_y),
        .o_gyro_z        (o_gyro_z),
        .o_pressure      (o_pressure),
        .o_temperature   (o_temperature),
        .o_altitude_bits (o_altitude_bits),
        .o_event_sum     (o_event_sum)
    );

endmodule

// File: design/slrp_front.sv
// Front end: byte intake, header check and payload collection.
module slrp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_log_byte,
    output logic           o_push,
    output slrp_pkg::t_rec o_rec
);
    import slrp_pkg::*;

    localparam logic [1:0] PH_HDR0    = 2'd0;
    localparam logic [1:0] PH_HDR1    = 2'd1;
    localparam logic [1:0] PH_HDR2    = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    logic [1:0]       r_phase, n_phase;
    logic [23:0]      r_hdr, n_hdr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_len, n_len;
    t_payload         r_buf, n_buf;
    logic             r_halted, n_halted;

    logic [23:0]      w_hdr_full;
    logic [3:0]       w_top;
    logic [CNT_W-1:0] w_len;
    logic [CNT_W-1:0] w_count_inc;

    assign w_hdr_full  = {r_hdr[23:8], i_log_byte};
    assign w_top       = w_hdr_full[23:20];
    assign w_count_inc = r_count + 1'b1;

    always_comb begin
        w_len = '0;
        if (w_top[FLAG_ACC])  w_len = w_len + LEN_ACC;
        if (w_top[FLAG_GYRO]) w_len = w_len + LEN_GYRO;
        if (w_top[FLAG_PRES]) w_len = w_len + LEN_PRES;
        if (w_top[FLAG_TEMP]) w_len = w_len + LEN_TEMP;
    end

    always_comb begin
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_count  = r_count;
        n_len    = r_len;
        n_buf    = r_buf;
        n_halted = r_halted;
        o_push   = 1'b0;
        o_rec.bad   = 1'b0;
        o_rec.flags = r_hdr[23:20];
        o_rec.evt   = r_hdr[19:12];
        o_rec.dt    = r_hdr[11:0];
        o_rec.bytes = r_buf;
        if (i_accept && !r_halted) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_hdr[23:16] = i_log_byte;
                    n_phase      = PH_HDR1;
                end
                PH_HDR1: begin
                    n_hdr[15:8] = i_log_byte;
                    n_phase     = PH_HDR2;
                end
                PH_HDR2: begin
                    n_hdr   = w_hdr_full;
                    n_count = '0;
                    n_len   = w_len;
                    if (w_top != HDR_TOP_SENSOR && w_top != HDR_TOP_FULL) begin
                        n_halted  = 1'b1;
                        o_push    = 1'b1;
                        o_rec.bad = 1'b1;
                        n_phase   = PH_HDR0;
                    end else if (w_len == '0) begin
                        o_push      = 1'b1;
                        o_rec.flags = w_hdr_full[23:20];
                        o_rec.evt   = w_hdr_full[19:12];
                        o_rec.dt    = w_hdr_full[11:0];
                        n_phase     = PH_HDR0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_count < CNT_W'(BUF_DEPTH)) begin
                        n_buf[r_count[IDX_W-1:0]] = i_log_byte;
                    end
                    n_count = w_count_inc;
                    if (w_count_inc >= r_len) begin
                        // The snapshot includes the byte arriving now.
                        o_push      = 1'b1;
                        o_rec.bytes = n_buf;
                        n_count     = '0;
                        n_phase     = PH_HDR0;
                    end
                end
                default: n_phase = PH_HDR0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_hdr    <= '0;
            r_count  <= '0;
            r_len    <= '0;
            r_buf    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_hdr    <= n_hdr;
            r_count  <= n_count;
            r_len    <= n_len;
            r_buf    <= n_buf;
            r_halted <= n_halted;
        end
    end

endmodule

// File: design/slrp_queue.sv
// Short record queue that decouples the front end from the back end.
module slrp_queue #(
    parameter int DEPTH = slrp_pkg::Q_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  slrp_pkg::t_rec i_rec,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_nonempty,
    output slrp_pkg::t_rec o_rec
);
    import slrp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_rec      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: design/slrp_back.sv
// Back end: sensor decode, time and event accumulation, result register.
module slrp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rec_valid,
    input  slrp_pkg::t_rec      i_rec,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_status,
    output logic [31:0]         o_abs_time,
    output logic signed [15:0]  o_accel_x,
    output logic signed [15:0]  o_accel_y,
    output logic signed [15:0]  o_accel_z,
    output logic signed [15:0]  o_gyro_x,
    output logic signed [15:0]  o_gyro_y,
    output logic signed [15:0]  o_gyro_z,
    output logic [23:0]         o_pressure,
    output logic [23:0]         o_temperature,
    output logic [31:0]         o_altitude_bits,
    output logic [7:0]          o_event_sum
);
    import slrp_pkg::*;

    logic        r_out_valid;
    logic        r_out_bad;
    logic [31:0] r_time;
    logic [7:0]  r_event;
    logic [15:0] r_acc  [3];
    logic [15:0] r_gyro [3];
    logic [23:0] r_pres;
    logic [23:0] r_temp;
    logic [31:0] r_alt;

    t_payload w_b;
    assign w_b = i_rec.bytes;

    // The sensor registers double as the result register, since they only
    // change when a new record is popped into an output slot that is empty or being read.
    assign o_pop = i_rec_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_bad   <= 1'b0;
            r_time      <= '0;
            r_event     <= '0;
            r_pres      <= '0;
            r_temp      <= '0;
            r_alt       <= '0;
            for (int i = 0; i < 3; i++) begin
                r_acc[i]  <= '0;
                r_gyro[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_out_bad   <= i_rec.bad;
                if (!i_rec.bad) begin
                    r_time  <= r_time + {20'd0, i_rec.dt};
                    r_event <= r_event + i_rec.evt;
                    if (i_rec.flags[FLAG_ACC]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_acc[i] <= {w_b[OFS_ACC + 2 * i], w_b[OFS_ACC + 2 * i + 1]};
                        end
                    end
                    if (i_rec.flags[FLAG_GYRO]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_gyro[i] <= {w_b[OFS_GYRO + 2 * i], w_b[OFS_GYRO + 2 * i + 1]};
                        end
                    end
                    if (i_rec.flags[FLAG_PRES]) begin
                        r_pres <= {w_b[OFS_PRES], w_b[OFS_PRES + 1], w_b[OFS_PRES + 2]};
                    end
                    if (i_rec.flags[FLAG_TEMP]) begin
                        r_temp <= {w_b[OFS_TEMP], w_b[OFS_TEMP + 1], w_b[OFS_TEMP + 2]};
                        r_alt  <= {w_b[OFS_ALT], w_b[OFS_ALT + 1],
                                   w_b[OFS_ALT + 2], w_b[OFS_ALT + 3]};
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A bad-header result shows zeros in every field but the status.
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_bad;
    assign o_abs_time      = r_out_bad ? '0 : r_time;
    assign o_accel_x       = r_out_bad ? '0 : $signed(r_acc[0]);
    assign o_accel_y       = r_out_bad ? '0 : $signed(r_acc[1]);
    assign o_accel_z       = r_out_bad ? '0 : $signed(r_acc[2]);
    assign o_gyro_x        = r_out_bad ? '0 : $signed(r_gyro[0]);
    assign o_gyro_y        = r_out_bad ? '0 : $signed(r_gyro[1]);
    assign o_gyro_z        = r_out_bad ? '0 : $signed(r_gyro[2]);
    assign o_pressure      = r_out_bad ? '0 : r_pres;
    assign o_temperature   = r_out_bad ? '0 : r_temp;
    assign o_altitude_bits = r_out_bad ? '0 : r_alt;
    assign o_event_sum     = r_out_bad ? '0 : r_event;

endmodule
